### design/hsfd_pkg.sv
// ----------------------------------------------------------------------------
// hsfd_pkg
// Shared types, constants and the CRC-8 byte fold for the frame decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hsfd_pkg;

    // crc-8 polynomial and start value (msb first, no reflection, no final xor)
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    // conversion scale factors
    localparam logic [14:0] TEMP_SCALE  = 15'd17500;
    localparam logic [13:0] HUM_SCALE   = 14'd10000;
    localparam logic [15:0] TEMP_OFFSET = 16'd4500;
    localparam logic [16:0] FULL_SCALE  = 17'd65535;

    // one received frame, handed from the assembler to the converter
    typedef struct packed {
        logic [15:0] raw_temperature;
        logic [15:0] raw_humidity;
        logic        temperature_crc_ok;
        logic        humidity_crc_ok;
    } frame_t;

    // fold one byte into the running crc, one bit per step
    function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### design/hsfd_frame.sv
// ----------------------------------------------------------------------------
// hsfd_frame
// Tracks the byte position, folds the crc and collects both words; on the
// sixth byte it loads one frame into its output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hsfd_frame
    import hsfd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] rx_byte,
    input  wire logic       frame_start,
    output logic            fr_valid,
    input  wire logic       fr_ready,
    output frame_t          fr
);

    typedef enum logic [2:0] {
        POS_T_HI  = 3'd0,
        POS_T_LO  = 3'd1,
        POS_T_CRC = 3'd2,
        POS_H_HI  = 3'd3,
        POS_H_LO  = 3'd4,
        POS_H_CRC = 3'd5
    } pos_t;

    pos_t        pos_reg, pos_next, pos_eff;
    logic [7:0]  crc_reg, crc_next;
    logic [15:0] held_t_reg, held_t_next;
    logic [15:0] held_h_reg, held_h_next;
    logic        t_pass_reg, t_pass_next;
    logic        fr_valid_reg, fr_valid_next;
    frame_t      fr_reg, fr_next;
    logic        in_fire, last_byte;

    assign in_ready = !fr_valid_reg || fr_ready;
    assign in_fire  = in_valid && in_ready;
    assign fr_valid = fr_valid_reg;
    assign fr       = fr_reg;

    // a frame start or an unused position restarts at byte 0
    always_comb
    begin
        if (frame_start)
            pos_eff = POS_T_HI;
        else
        begin
            unique case (pos_reg)
                POS_T_HI, POS_T_LO, POS_T_CRC,
                POS_H_HI, POS_H_LO, POS_H_CRC: pos_eff = pos_reg;
                default:                       pos_eff = POS_T_HI;
            endcase
        end
    end

    // per-byte state update
    always_comb
    begin
        pos_next    = pos_reg;
        crc_next    = crc_reg;
        held_t_next = held_t_reg;
        held_h_next = held_h_reg;
        t_pass_next = t_pass_reg;
        last_byte   = 1'b0;
        fr_next     = fr_reg;
        if (in_fire)
        begin
            unique case (pos_eff)
                POS_T_HI:
                begin
                    crc_next    = crc_fold(CRC_INIT, rx_byte);
                    held_t_next = {rx_byte, 8'h00};
                    pos_next    = POS_T_LO;
                end
                POS_T_LO:
                begin
                    crc_next    = crc_fold(crc_reg, rx_byte);
                    held_t_next = {held_t_reg[15:8], rx_byte};
                    pos_next    = POS_T_CRC;
                end
                POS_T_CRC:
                begin
                    t_pass_next = (crc_reg == rx_byte);
                    crc_next    = CRC_INIT;
                    pos_next    = POS_H_HI;
                end
                POS_H_HI:
                begin
                    crc_next    = crc_fold(CRC_INIT, rx_byte);
                    held_h_next = {rx_byte, 8'h00};
                    pos_next    = POS_H_LO;
                end
                POS_H_LO:
                begin
                    crc_next    = crc_fold(crc_reg, rx_byte);
                    held_h_next = {held_h_reg[15:8], rx_byte};
                    pos_next    = POS_H_CRC;
                end
                default:
                begin
                    last_byte                  = 1'b1;
                    fr_next.raw_temperature    = held_t_reg;
                    fr_next.raw_humidity       = held_h_reg;
                    fr_next.temperature_crc_ok = t_pass_reg;
                    fr_next.humidity_crc_ok    = (crc_reg == rx_byte);
                    crc_next                   = CRC_INIT;
                    pos_next                   = POS_T_HI;
                end
            endcase
        end
    end

    // frame register handshake
    always_comb
    begin
        if (last_byte)
            fr_valid_next = 1'b1;
        else if (fr_ready)
            fr_valid_next = 1'b0;
        else
            fr_valid_next = fr_valid_reg;
    end

    // state and frame registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= POS_T_HI;
            crc_reg      <= CRC_INIT;
            held_t_reg   <= '0;
            held_h_reg   <= '0;
            t_pass_reg   <= 1'b0;
            fr_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg      <= pos_next;
            crc_reg      <= crc_next;
            held_t_reg   <= held_t_next;
            held_h_reg   <= held_h_next;
            t_pass_reg   <= t_pass_next;
            fr_valid_reg <= fr_valid_next;
        end
    end

    // frame payload
    always_ff @(posedge clk)
    begin
        fr_reg <= fr_next;
    end

endmodule

`default_nettype wire

### design/hsfd_conv.sv
// ----------------------------------------------------------------------------
// hsfd_conv
// Scales the raw words to hundredths: a multiply stage, then a divide by
// 65535 done as a shift, an add and one compare into the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hsfd_conv
    import hsfd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        fr_valid,
    output logic             fr_ready,
    input  wire frame_t      fr,
    output logic             res_valid,
    input  wire logic        res_ready,
    output logic [63:0]      res_data
);

    logic        b_valid_reg, b_ready;
    logic [30:0] prod_t_reg;
    logic [29:0] prod_h_reg;
    frame_t      b_fr_reg;
    logic        c_valid_reg, c_ready;
    logic [63:0] c_data_reg;

    // floor(x / 65535) for x = a*65536 + b: a plus one when a + b reaches 65535
    logic [16:0] t_sum, h_sum;
    logic [15:0] t_quot;
    logic [13:0] h_quot;
    logic [15:0] temp_val;

    assign b_ready   = !b_valid_reg || c_ready;
    assign c_ready   = !c_valid_reg || res_ready;
    assign fr_ready  = b_ready;
    assign res_valid = c_valid_reg;
    assign res_data  = c_data_reg;

    // divide by full scale and remove the temperature offset
    always_comb
    begin
        t_sum    = {2'b00, prod_t_reg[30:16]} + {1'b0, prod_t_reg[15:0]};
        h_sum    = {3'b000, prod_h_reg[29:16]} + {1'b0, prod_h_reg[15:0]};
        t_quot   = {1'b0, prod_t_reg[30:16]} + {15'd0, (t_sum >= FULL_SCALE)};
        h_quot   = prod_h_reg[29:16] + {13'd0, (h_sum >= FULL_SCALE)};
        temp_val = t_quot - TEMP_OFFSET;
    end

    // control of both stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (b_ready)
                b_valid_reg <= fr_valid;
            if (c_ready)
                c_valid_reg <= b_valid_reg;
        end
    end

    // multiply stage and result register
    always_ff @(posedge clk)
    begin
        if (b_ready && fr_valid)
        begin
            prod_t_reg <= 31'(fr.raw_temperature * TEMP_SCALE);
            prod_h_reg <= 30'(fr.raw_humidity * HUM_SCALE);
            b_fr_reg   <= fr;
        end
        if (c_ready && b_valid_reg)
        begin
            c_data_reg <= {1'b0,
                           b_fr_reg.humidity_crc_ok,
                           b_fr_reg.temperature_crc_ok,
                           b_fr_reg.raw_humidity,
                           b_fr_reg.raw_temperature,
                           h_quot,
                           temp_val[14:0]};
        end
    end

endmodule

`default_nettype wire

### design/humidity_sensor_frame_decoder.sv
// ----------------------------------------------------------------------------
// humidity_sensor_frame_decoder
// Decodes six-byte temperature/humidity measurement frames with CRC-8 checks.
// ----------------------------------------------------------------------------
// Bytes arrive one word per cycle on the slave stream, in wire order:
// temperature high, low, crc, humidity high, low, crc. tuser marks the first
// byte of a frame and resynchronizes the position; without it the count just
// wraps after six bytes. Every sixth byte yields one result word through
// the frame register, multiply register and result register, whether or not
// the crc matched; a failed check only clears its flag. A byte can be taken
// every cycle, and the pipeline keeps accepting while a result waits on the
// master side, until all three registers hold a frame.
`timescale 1ns / 1ps
`default_nettype none

module humidity_sensor_frame_decoder
    import hsfd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic        s_tuser,   // [0] frame_start
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [14:0] temperature_centi, [28:15] humidity_centi, [44:29] raw_temperature,
    // [60:45] raw_humidity, [61] temperature_crc_ok, [62] humidity_crc_ok
    output logic [63:0]      m_tdata
);

    logic   fr_valid, fr_ready;
    frame_t fr;

    // byte collection and crc checks
    hsfd_frame u_frame (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .rx_byte     (s_tdata),
        .frame_start (s_tuser),
        .fr_valid    (fr_valid),
        .fr_ready    (fr_ready),
        .fr          (fr)
    );

    // unit conversion
    hsfd_conv u_conv (
        .clk       (clk),
        .rst_n     (rst_n),
        .fr_valid  (fr_valid),
        .fr_ready  (fr_ready),
        .fr        (fr),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res_data  (m_tdata)
    );

    // converted values stay within their ranges
    a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[28:15] <= 14'd10000))
        else $error("humidity above full scale");

    a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[14:0]) >= -15'sd4500))
        else $error("temperature below lower limit");

    // full-scale humidity only from an all-ones raw word
    a_hum_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[28:15] == 14'd10000) == (m_tdata[60:45] == 16'hFFFF)))
        else $error("humidity full scale mismatch");

    // an empty frame register never stalls the byte stream
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !fr_valid |-> s_tready)
        else $error("byte input stalled with free frame register");

endmodule

`default_nettype wire
